// ----- src/icmprm_pkg.sv -----
// Shared constants, codes and types for the ICMPv6 reply matcher.
package icmprm_pkg;

  localparam int DEF_MAX_FRAME_BYTES = 4096;

  // Frame offsets
  localparam int ETH_LEN      = 14;
  localparam int IP6_LEN      = 40;
  localparam int ICMP_HDR_LEN = 8;
  localparam int POS_NXT      = ETH_LEN + 6;
  localparam int POS_SRC      = ETH_LEN + 8;
  localparam int SRC_BYTES    = 16;
  localparam int POS_ICMP     = ETH_LEN + IP6_LEN;
  localparam int POS_HBH      = POS_ICMP + ICMP_HDR_LEN + IP6_LEN;

  // Inner ICMP offset reaches POS_HBH + 256*8 + 23
  localparam int OFS_W = 12;

  localparam logic [7:0] NH_ICMPV6    = 8'h3a;
  localparam logic [7:0] TYPE_PARAM_PROBLEM = 8'd4;

  // Round-trip arithmetic
  localparam int TW      = 42;
  localparam int PROD_W  = 63;
  localparam logic signed [20:0] USEC_PER_SEC  = 21'sd1000000;
  localparam logic signed [63:0] SEND_LIM      = 64'sh0000_0100_0000_0000;
  localparam logic signed [63:0] SEND_LIM_NEG  = -64'sh0000_0100_0000_0000;
  localparam logic signed [31:0] RTT_MAX       = 32'sh7fff_ffff;
  localparam logic signed [31:0] RTT_MIN       = 32'sh8000_0000;

  // Status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NOT_ICMP     = 3'd1;
  localparam logic [2:0] ST_SRC_MISMATCH = 3'd2;
  localparam logic [2:0] ST_TOO_SHORT    = 3'd3;
  localparam logic [2:0] ST_INNER_BAD    = 3'd4;
  localparam logic [2:0] ST_ID_MISMATCH  = 3'd5;

  // Method codes
  localparam logic [1:0] M_DIRECT  = 2'd0;
  localparam logic [1:0] M_PARAM   = 2'd1;
  localparam logic [1:0] M_FOREIGN = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_EN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LOW  = 3'd4;

  typedef struct packed {
    logic [15:0] expected_id;
    logic [15:0] own_id;
    logic        filter_en;
    logic [63:0] target_high;
    logic [63:0] target_low;
  } cfg_t;

  typedef struct packed {
    logic             nh_ok;
    logic             pp;
    logic             inner_ok;
    logic [OFS_W-1:0] inner_off;
    logic [15:0]      id;
    logic [63:0]      src_high;
    logic [63:0]      src_low;
    logic [63:0]      send_sec;
    logic [63:0]      send_usec;
    logic [31:0]      recv_sec;
    logic [19:0]      recv_usec;
  } frame_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [1:0]          method;
    logic [63:0]         src_high;
    logic [63:0]         src_low;
    logic signed [TW-1:0] ds;
    logic signed [TW-1:0] du;
  } verdict_t;

endpackage

// ----- src/icmprm_parser.sv -----
// Input register and per-byte frame parser; emits a frame summary on the last byte.
module icmprm_parser #(
  parameter int MAX_FRAME_BYTES = icmprm_pkg::DEF_MAX_FRAME_BYTES,
  parameter int LEN_W = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic [31:0]          recv_seconds,
  input  logic [19:0]          recv_microseconds,
  output logic                 frm_valid,
  input  logic                 frm_ready,
  output icmprm_pkg::frame_t   frm,
  output logic [LEN_W-1:0]     frm_len
);
  import icmprm_pkg::*;

  localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

  logic             v0;
  logic [7:0]       b0;
  logic             last0;
  logic [31:0]      rs0;
  logic [19:0]      ru0;

  logic [PW-1:0]    pos;
  logic             nh_ok;
  logic             pp;
  logic             inner_ok;
  logic [OFS_W-1:0] inner_off;
  logic [15:0]      id;
  logic [15:0][7:0] src;
  logic [7:0][7:0]  sec;
  logic [7:0][7:0]  usec;

  logic [PW-1:0]    pos_next;
  logic             nh_ok_next;
  logic             pp_next;
  logic             inner_ok_next;
  logic [OFS_W-1:0] inner_off_next;
  logic [15:0]      id_next;
  logic [15:0][7:0] src_next;
  logic [7:0][7:0]  sec_next;
  logic [7:0][7:0]  usec_next;

  logic             take;
  logic             live;
  logic [LEN_W-1:0] p;
  logic [LEN_W-1:0] icmp;
  logic [LEN_W-1:0] d;
  logic [3:0]       k;

  assign take     = v0 && (!last0 || !frm_valid || frm_ready);
  assign in_ready = !v0 || take;

  always_comb begin
    live = pos < PW'(MAX_FRAME_BYTES);
    p    = LEN_W'(pos);
    icmp = pp ? LEN_W'(inner_off) : LEN_W'(POS_ICMP);
    d    = p - icmp;
    k    = 4'(p - LEN_W'(POS_SRC));

    pos_next       = pos;
    nh_ok_next     = nh_ok;
    pp_next        = pp;
    inner_ok_next  = inner_ok;
    inner_off_next = inner_off;
    id_next        = id;
    src_next       = src;
    sec_next       = sec;
    usec_next      = usec;

    if (live) begin
      pos_next = pos + PW'(1);
      if (p == LEN_W'(POS_NXT)) nh_ok_next = (b0 == NH_ICMPV6);
      if (p >= LEN_W'(POS_SRC) && p < LEN_W'(POS_SRC + SRC_BYTES)) begin
        src_next[4'd15 - k] = b0;
      end
      if (p == LEN_W'(POS_ICMP)) pp_next = (b0 == TYPE_PARAM_PROBLEM);
      if (pp) begin
        if (p == LEN_W'(POS_HBH)) inner_ok_next = (b0 == NH_ICMPV6);
        if (p == LEN_W'(POS_HBH + 1)) begin
          inner_off_next = OFS_W'(POS_HBH) + ((OFS_W'(b0) + OFS_W'(1)) << 3);
        end
      end
      if (p > LEN_W'(POS_ICMP) && p >= icmp) begin
        if (d == LEN_W'(4)) id_next[7:0] = b0;
        if (d == LEN_W'(5)) id_next[15:8] = b0;
        if (d >= LEN_W'(8) && d < LEN_W'(16)) sec_next[d[2:0]] = b0;
        if (d >= LEN_W'(16) && d < LEN_W'(24)) usec_next[d[2:0]] = b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (in_ready) begin
      v0 <= in_valid;
    end
    if (in_valid && in_ready) begin
      b0    <= data_byte;
      last0 <= last_byte;
      rs0   <= recv_seconds;
      ru0   <= recv_microseconds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last0)) begin
      pos       <= '0;
      nh_ok     <= 1'b0;
      pp        <= 1'b0;
      inner_ok  <= 1'b0;
      inner_off <= '0;
      id        <= '0;
      src       <= '0;
      sec       <= '0;
      usec      <= '0;
    end else if (take) begin
      pos       <= pos_next;
      nh_ok     <= nh_ok_next;
      pp        <= pp_next;
      inner_ok  <= inner_ok_next;
      inner_off <= inner_off_next;
      id        <= id_next;
      src       <= src_next;
      sec       <= sec_next;
      usec      <= usec_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frm_valid <= 1'b0;
    end else if (!frm_valid || frm_ready) begin
      frm_valid <= take && last0;
    end
    if (take && last0) begin
      frm.nh_ok     <= nh_ok_next;
      frm.pp        <= pp_next;
      frm.inner_ok  <= inner_ok_next;
      frm.inner_off <= inner_off_next;
      frm.id        <= id_next;
      frm.src_high  <= src_next[15:8];
      frm.src_low   <= src_next[7:0];
      frm.send_sec  <= sec_next;
      frm.send_usec <= usec_next;
      frm.recv_sec  <= rs0;
      frm.recv_usec <= ru0;
      frm_len       <= LEN_W'(pos_next);
    end
  end

endmodule

// ----- src/icmprm_verdict.sv -----
// Verdict stage: status and method checks, clamped send time differences.
module icmprm_verdict #(
  parameter int LEN_W = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  icmprm_pkg::cfg_t     cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  icmprm_pkg::frame_t   frm,
  input  logic [LEN_W-1:0]     len,
  output logic                 out_valid,
  input  logic                 out_ready,
  output icmprm_pkg::verdict_t vd
);
  import icmprm_pkg::*;

  logic [LEN_W-1:0]     icmp;
  logic                 src_hit;
  logic [2:0]           status;
  logic [1:0]           method;
  logic signed [63:0]   sec_s;
  logic signed [63:0]   usec_s;
  logic signed [TW-1:0] ss;
  logic signed [TW-1:0] su;
  logic signed [TW-1:0] ds;
  logic signed [TW-1:0] du;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    icmp    = frm.pp ? LEN_W'(frm.inner_off) : LEN_W'(POS_ICMP);
    src_hit = (frm.src_high == cfg.target_high) && (frm.src_low == cfg.target_low);

    status = ST_OK;
    if (len <= LEN_W'(POS_NXT)) status = ST_TOO_SHORT;
    else if (!frm.nh_ok) status = ST_NOT_ICMP;
    else if (cfg.filter_en && len < LEN_W'(POS_SRC + SRC_BYTES)) status = ST_TOO_SHORT;
    else if (cfg.filter_en && !src_hit) status = ST_SRC_MISMATCH;
    else if (len <= LEN_W'(POS_ICMP)) status = ST_TOO_SHORT;
    else if (frm.pp && len <= LEN_W'(POS_HBH)) status = ST_TOO_SHORT;
    else if (frm.pp && !frm.inner_ok) status = ST_INNER_BAD;
    else if (frm.pp && len <= LEN_W'(POS_HBH + 1)) status = ST_TOO_SHORT;
    else if (len <= icmp + LEN_W'(5)) status = ST_TOO_SHORT;
    else if (frm.id != cfg.expected_id) status = ST_ID_MISMATCH;
    else if (len <= icmp + LEN_W'(23)) status = ST_TOO_SHORT;

    if (status != ST_OK) method = M_DIRECT;
    else if (frm.pp) method = M_PARAM;
    else if (frm.id != cfg.own_id) method = M_FOREIGN;
    else method = M_DIRECT;

    sec_s  = $signed(frm.send_sec);
    usec_s = $signed(frm.send_usec);
    if (sec_s > SEND_LIM) ss = SEND_LIM[TW-1:0];
    else if (sec_s < SEND_LIM_NEG) ss = SEND_LIM_NEG[TW-1:0];
    else ss = $signed(sec_s[TW-1:0]);
    if (usec_s > SEND_LIM) su = SEND_LIM[TW-1:0];
    else if (usec_s < SEND_LIM_NEG) su = SEND_LIM_NEG[TW-1:0];
    else su = $signed(usec_s[TW-1:0]);

    if (status == ST_OK) begin
      ds = $signed({{(TW-32){1'b0}}, frm.recv_sec}) - ss;
      du = $signed({{(TW-20){1'b0}}, frm.recv_usec}) - su;
    end else begin
      ds = '0;
      du = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      vd.status   <= status;
      vd.method   <= method;
      vd.src_high <= frm.src_high;
      vd.src_low  <= frm.src_low;
      vd.ds       <= ds;
      vd.du       <= du;
    end
  end

endmodule

// ----- src/icmprm_rtt.sv -----
// Round-trip time: seconds scaling stage, then add, saturate and result register.
module icmprm_rtt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  icmprm_pkg::verdict_t vd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           status,
  output logic [1:0]           method,
  output logic [63:0]          source_addr_high,
  output logic [63:0]          source_addr_low,
  output logic [31:0]          round_trip_us
);
  import icmprm_pkg::*;

  logic                     mv;
  logic                     m_ready;
  logic [2:0]               m_status;
  logic [1:0]               m_method;
  logic [63:0]              m_src_high;
  logic [63:0]              m_src_low;
  logic signed [PROD_W-1:0] prod;
  logic signed [TW-1:0]     m_du;

  logic signed [PROD_W-1:0] prod_next;
  logic signed [PROD_W:0]   total;
  logic [31:0]              rtt_next;

  assign m_ready  = !out_valid || out_ready;
  assign in_ready = !mv || m_ready;

  always_comb begin
    prod_next = $signed(vd.ds) * USEC_PER_SEC;
    total     = prod + m_du;
    if (total > RTT_MAX) rtt_next = RTT_MAX;
    else if (total < RTT_MIN) rtt_next = RTT_MIN;
    else rtt_next = total[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (in_ready) begin
      mv <= in_valid;
    end
    if (in_valid && in_ready) begin
      m_status   <= vd.status;
      m_method   <= vd.method;
      m_src_high <= vd.src_high;
      m_src_low  <= vd.src_low;
      prod       <= prod_next;
      m_du       <= vd.du;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (m_ready) begin
      out_valid <= mv;
    end
    if (mv && m_ready) begin
      status           <= m_status;
      method           <= m_method;
      source_addr_high <= m_src_high;
      source_addr_low  <= m_src_low;
      round_trip_us    <= rtt_next;
    end
  end

endmodule

// ----- src/icmpv6_reply_matcher_rtt_top.sv -----
// Top level of the ICMPv6 reply matcher with round-trip time.
//
//   channel  direction  handshake            payload
//   s_       in         s_tvalid / s_tready  s_tdata, s_tlast (one frame byte per item)
//   m_       out        m_tvalid / m_tready  m_tdata (one verdict per frame)
//   cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data (register write)
//
// One byte item per cycle while s_tready is high. After the last byte is accepted,
// a verdict passes in turn through input register, parser, verdict, seconds scaling, saturate.
// Reset is synchronous; it clears frame state, pipeline valids and config registers.
// s_tready drops only when the input register holds a last byte, every later stage is full and m_tready is low.
module icmpv6_reply_matcher_rtt_top #(
  parameter int MAX_FRAME_BYTES = icmprm_pkg::DEF_MAX_FRAME_BYTES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [63:0]                      s_tdata,  // data_byte, recv_seconds, recv_microseconds
  input  logic                             s_tlast,  // last_byte
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [167:0]                     m_tdata,  // status, method, source_addr_high,
                                                     // source_addr_low, round_trip_us
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [icmprm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                      cfg_data
);
  import icmprm_pkg::*;

  localparam int PW    = $clog2(MAX_FRAME_BYTES + 1);
  localparam int LEN_W = (PW > OFS_W) ? PW : OFS_W;

  cfg_t             cfg;
  logic             frm_valid;
  logic             frm_ready;
  frame_t           frm;
  logic [LEN_W-1:0] frm_len;
  logic             vd_valid;
  logic             vd_ready;
  verdict_t         vd;
  logic [2:0]       status;
  logic [1:0]       method;
  logic [63:0]      source_addr_high;
  logic [63:0]      source_addr_low;
  logic [31:0]      round_trip_us;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_EXPECTED_ID: cfg.expected_id <= cfg_data[15:0];
        CFG_OWN_ID:      cfg.own_id      <= cfg_data[15:0];
        CFG_FILTER_EN:   cfg.filter_en   <= cfg_data[0];
        CFG_TARGET_HIGH: cfg.target_high <= cfg_data;
        CFG_TARGET_LOW:  cfg.target_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  icmprm_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .LEN_W(LEN_W)
  ) u_parser (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .data_byte(s_tdata[7:0]),
    .last_byte(s_tlast),
    .recv_seconds(s_tdata[39:8]),
    .recv_microseconds(s_tdata[59:40]),
    .frm_valid(frm_valid),
    .frm_ready(frm_ready),
    .frm(frm),
    .frm_len(frm_len)
  );

  icmprm_verdict #(
    .LEN_W(LEN_W)
  ) u_verdict (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_valid(frm_valid),
    .in_ready(frm_ready),
    .frm(frm),
    .len(frm_len),
    .out_valid(vd_valid),
    .out_ready(vd_ready),
    .vd(vd)
  );

  icmprm_rtt u_rtt (
    .clk(clk),
    .rst(rst),
    .in_valid(vd_valid),
    .in_ready(vd_ready),
    .vd(vd),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .status(status),
    .method(method),
    .source_addr_high(source_addr_high),
    .source_addr_low(source_addr_low),
    .round_trip_us(round_trip_us)
  );

  assign m_tdata = {3'b000, round_trip_us, source_addr_low, source_addr_high, method, status};

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled while the pipeline has room");

  a_reject_is_bare: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status != ST_OK |-> method == M_DIRECT && round_trip_us == 32'd0)
    else $error("rejected frame carries method or round-trip time");

  a_foreign_is_accepted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (method == M_FOREIGN || method == M_PARAM) |-> status == ST_OK)
    else $error("method set on a rejected frame");

endmodule
